// ===== rtl/q15_biquad_cascade_iir_macros.svh =====
// ----------------------------------------------------------------------------
// q15 biquad cascade assertion macros
// shared concurrent assertion forms, clocked on clk and off during reset
// ----------------------------------------------------------------------------
`ifndef Q15_BIQUAD_CASCADE_IIR_MACROS_SVH
`define Q15_BIQUAD_CASCADE_IIR_MACROS_SVH

// same-cycle implication
`define Q15BQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define Q15BQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/q15bq_pkg.sv =====
// ----------------------------------------------------------------------------
// q15bq_pkg
// widths, register map and shared types of the q15 biquad cascade
// ----------------------------------------------------------------------------
package q15bq_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FRAC_BITS = 15;
	localparam int COEF_W    = 16;
	localparam int ACC_W     = 32;
	localparam int NUM_COEFS = 8;
	localparam int REG_IDX_W = $clog2(NUM_COEFS);

	// two coefficient bits per mac cycle
	localparam int NUM_DIGITS = COEF_W / 2;
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic        [ACC_W-1:0]    acc_t;

	// register map
	localparam logic [REG_IDX_W-1:0] REG_S1_A1 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_S1_A2 = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_S1_B0 = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_S1_B2 = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_S2_A1 = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_S2_A2 = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_S2_B0 = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_S2_B2 = REG_IDX_W'(7);

	localparam coef_t COEF_RESET [NUM_COEFS] = '{
		COEF_W'(31061), COEF_W'(-24444), COEF_W'(8959), COEF_W'(-8959),
		COEF_W'(20116), COEF_W'(-27692), COEF_W'(5462), COEF_W'(-5462)
	};

	// sequencer steps
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_S1_X    = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_S1_A1   = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_S1_A2   = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_S1_W    = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_S1_B0   = STEP_W'(4);
	localparam logic [STEP_W-1:0] STEP_S1_B2   = STEP_W'(5);
	localparam logic [STEP_W-1:0] STEP_S1_Y    = STEP_W'(6);
	localparam logic [STEP_W-1:0] STEP_S2_UNIT = STEP_W'(7);
	localparam logic [STEP_W-1:0] STEP_S2_A1   = STEP_W'(8);
	localparam logic [STEP_W-1:0] STEP_S2_A2   = STEP_W'(9);
	localparam logic [STEP_W-1:0] STEP_S2_W    = STEP_W'(10);
	localparam logic [STEP_W-1:0] STEP_S2_B0   = STEP_W'(11);
	localparam logic [STEP_W-1:0] STEP_S2_B2   = STEP_W'(12);
	localparam logic [STEP_W-1:0] STEP_S2_Y    = STEP_W'(13);

	// mac command
	typedef struct packed {
		logic preset;   // acc = operand << FRAC_BITS
		logic add_sh;   // acc += operand << FRAC_BITS
		logic start;    // begin operand * coef, accumulated
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic last;     // final digit is being added this cycle
	} mac_stat_t;

	// arithmetic shift by FRAC_BITS then wrap to the sample width
	function automatic sample_t rescale(input acc_t a);
		rescale = a[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
	endfunction

endpackage

// ===== rtl/q15_biquad_cascade_iir.sv =====
// ----------------------------------------------------------------------------
// q15_biquad_cascade_iir
// two direct-form-II biquad sections in cascade, q15, one shared serial mac
// ----------------------------------------------------------------------------
// out_valid is registered from the final step, after the accepted input request
// in_stall holds until a sample is done; eight products, each issued then summed
//   digit by digit, plus six add/rescale steps, all on one mac
// a stalled result holds the last step until the output register frees up
// reset: coefficients return to their defaults, delay words and handshake clear
// ----------------------------------------------------------------------------
module q15_biquad_cascade_iir (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input sample channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  q15bq_pkg::sample_t                    sample_in,
	// output sample channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output q15bq_pkg::sample_t                    sample_out,
	// coefficient write port
	input  logic                                  cfg_we,
	input  logic [q15bq_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [q15bq_pkg::COEF_W-1:0]           cfg_data
);
	import q15bq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ISSUE = 3'b010,
		ST_WAIT  = 3'b100
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;

	coef_t   coef_q [NUM_COEFS];
	sample_t x_q;        // captured input request
	sample_t w_q;        // new state word of the current section
	sample_t s1_d1_q, s1_d2_q, s2_d1_q, s2_d2_q;
	sample_t sample_out_q;
	logic    out_valid_q;

	mac_cmd_t  mac_cmd;
	mac_stat_t mac_stat;
	sample_t   mac_op;
	coef_t     mac_coef;
	acc_t      acc;
	sample_t   resc;

	logic in_acc;
	logic out_take;
	logic out_free;
	logic step_done;   // current issue step completes this cycle
	logic last_step;   // final step of the sequence is active

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign out_take  = out_valid_q & ~out_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign resc      = rescale(acc);
	assign last_step = (state_q == ST_ISSUE) && (step_q == STEP_S2_Y);

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= COEF_RESET[i];
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// per-step operand routing and mac command
	always_comb begin
		mac_cmd   = '0;
		mac_op    = '0;
		mac_coef  = '0;
		step_done = 1'b1;
		if (state_q == ST_ISSUE) begin
			unique case (step_q) inside
				// section one: w = x<<15 + a1*d1 + a2*d2
				STEP_S1_X: begin
					mac_cmd.preset = 1'b1;
					mac_op         = x_q;
				end
				STEP_S1_A1: begin
					mac_cmd.start = 1'b1;
					mac_op        = s1_d1_q;
					mac_coef      = coef_q[REG_S1_A1];
				end
				STEP_S1_A2: begin
					mac_cmd.start = 1'b1;
					mac_op        = s1_d2_q;
					mac_coef      = coef_q[REG_S1_A2];
				end
				// capture w and clear the accumulator
				STEP_S1_W, STEP_S2_W: begin
					mac_cmd.preset = 1'b1;
				end
				// section one: y = b0*w + b2*d2
				STEP_S1_B0: begin
					mac_cmd.start = 1'b1;
					mac_op        = w_q;
					mac_coef      = coef_q[REG_S1_B0];
				end
				STEP_S1_B2: begin
					mac_cmd.start = 1'b1;
					mac_op        = s1_d2_q;
					mac_coef      = coef_q[REG_S1_B2];
				end
				// section one output seeds section two's sum
				STEP_S1_Y: begin
					mac_cmd.preset = 1'b1;
					mac_op         = resc;
				end
				// unit part of section two's first feedback coefficient
				STEP_S2_UNIT: begin
					mac_cmd.add_sh = 1'b1;
					mac_op         = s2_d1_q;
				end
				STEP_S2_A1: begin
					mac_cmd.start = 1'b1;
					mac_op        = s2_d1_q;
					mac_coef      = coef_q[REG_S2_A1];
				end
				STEP_S2_A2: begin
					mac_cmd.start = 1'b1;
					mac_op        = s2_d2_q;
					mac_coef      = coef_q[REG_S2_A2];
				end
				STEP_S2_B0: begin
					mac_cmd.start = 1'b1;
					mac_op        = w_q;
					mac_coef      = coef_q[REG_S2_B0];
				end
				STEP_S2_B2: begin
					mac_cmd.start = 1'b1;
					mac_op        = s2_d2_q;
					mac_coef      = coef_q[REG_S2_B2];
				end
				// final output waits for room in the output register
				STEP_S2_Y: begin
					step_done = out_free;
				end
				default: begin
					step_done = 1'b1;
				end
			endcase
		end
	end

	q15bq_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mac_cmd),
		.operand (mac_op),
		.coef    (mac_coef),
		.stat    (mac_stat),
		.acc     (acc)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_S1_X;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_ISSUE;
						step_q  <= STEP_S1_X;
					end
				end
				ST_ISSUE: begin
					if (mac_cmd.start) begin
						state_q <= ST_WAIT;
					end else if (step_done) begin
						if (step_q == STEP_S2_Y) begin
							state_q <= ST_IDLE;
						end
						step_q <= step_q + STEP_W'(1);
					end
				end
				ST_WAIT: begin
					// move on as the last digit lands in the accumulator
					if (mac_stat.last) begin
						state_q <= ST_ISSUE;
						step_q  <= step_q + STEP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// delay words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_d1_q <= '0;
			s1_d2_q <= '0;
			s2_d1_q <= '0;
			s2_d2_q <= '0;
		end else if (state_q == ST_ISSUE) begin
			if (step_q == STEP_S1_Y) begin
				s1_d2_q <= s1_d1_q;
				s1_d1_q <= w_q;
			end
			if (last_step && step_done) begin
				s2_d2_q <= s2_d1_q;
				s2_d1_q <= w_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= sample_in;
		end
		if (state_q == ST_ISSUE && (step_q == STEP_S1_W || step_q == STEP_S2_W)) begin
			w_q <= resc;
		end
		if (last_step && step_done) begin
			sample_out_q <= resc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_step && step_done) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

	// checks
	`include "q15_biquad_cascade_iir_macros.svh"

	`Q15BQ_ASSERT_NXT(a_busy_after_req, in_acc, in_stall, "no stall after accepted request")
	`Q15BQ_ASSERT_IMP(a_mac_idle, state_q == ST_IDLE, !mac_stat.busy, "mac busy while idle")
	`Q15BQ_ASSERT_IMP(a_out_from_last, $rose(out_valid_q), $past(last_step), "early result")
	`Q15BQ_ASSERT_IMP(a_no_overwrite, last_step && out_valid_q && out_stall, !step_done, "result lost")

endmodule

// ===== rtl/q15bq_mac.sv =====
// ----------------------------------------------------------------------------
// q15bq_mac
// digit-serial multiply-accumulate, two coefficient bits per cycle
// ----------------------------------------------------------------------------
module q15bq_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  q15bq_pkg::mac_cmd_t cmd,
	input  q15bq_pkg::sample_t  operand,
	input  q15bq_pkg::coef_t    coef,
	output q15bq_pkg::mac_stat_t stat,
	output q15bq_pkg::acc_t     acc
);
	import q15bq_pkg::*;

	acc_t                 acc_q;
	acc_t                 m_q;      // multiplicand, shifted left two per digit
	acc_t                 m3_q;     // three times multiplicand, same shifting
	logic [COEF_W-1:0]    c_q;      // coefficient, shifted right two per digit
	logic [DIG_CNT_W-1:0] cnt_q;

	acc_t       op_ext;
	acc_t       term;
	acc_t       acc_nxt;
	logic       last;
	logic       sub;

	assign op_ext = ACC_W'(operand);
	assign last   = (cnt_q == DIG_CNT_W'(1));
	// top digit carries negative weight: 10 is -2, 11 is -1
	assign sub    = last & c_q[1];

	always_comb begin
		case (c_q[1:0])
			2'b00: term = '0;
			2'b01: term = m_q;
			2'b10: term = m_q << 1;
			default: term = last ? m_q : m3_q;
		endcase
		acc_nxt = sub ? (acc_q - term) : (acc_q + term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= DIG_CNT_W'(NUM_DIGITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIG_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.preset) begin
			acc_q <= op_ext << FRAC_BITS;
		end else if (cmd.add_sh) begin
			acc_q <= acc_q + (op_ext << FRAC_BITS);
		end else if (cnt_q != '0) begin
			acc_q <= acc_nxt;
		end
		if (cmd.start) begin
			m_q  <= op_ext;
			m3_q <= op_ext + (op_ext << 1);
			c_q  <= coef;
		end else begin
			m_q  <= m_q << 2;
			m3_q <= m3_q << 2;
			c_q  <= c_q >> 2;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.last = last;
	assign acc       = acc_q;

endmodule
